// ===== hdl/priority_ready_queue_top_assert.svh =====
// assertion macros used by the ready queue datapath
`ifndef PRIORITY_READY_QUEUE_TOP_ASSERT_SVH
`define PRIORITY_READY_QUEUE_TOP_ASSERT_SVH

// condition that must hold at every edge out of reset
`define PRQ_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// consequent checked in the same cycle as the antecedent
`define PRQ_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the cycle after the antecedent
`define PRQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/prq_pkg.sv =====
// shared types and constants of the priority ready queue
package prq_pkg;

  localparam int MODE_W = 3;
  localparam int PID_W  = 16;
  localparam int KEY_W  = 16;
  localparam int PRIO_W = 8;
  localparam int STAT_W = 2;

  localparam logic [MODE_W-1:0] MODE_ENQ      = 3'd0;
  localparam logic [MODE_W-1:0] MODE_INS      = 3'd1;
  localparam logic [MODE_W-1:0] MODE_DEQ      = 3'd2;
  localparam logic [MODE_W-1:0] MODE_FIND_PID = 3'd3;
  localparam logic [MODE_W-1:0] MODE_FIND_KEY = 3'd4;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_MISS  = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd3;

  localparam logic [KEY_W-1:0] FIRST_KEY = 16'd99;

  typedef struct packed {
    logic [PID_W-1:0]         pid;
    logic signed [KEY_W-1:0]  key;
    logic [PRIO_W-1:0]        prio;
  } entry_t;

  typedef enum logic [1:0] {
    SRC_ZERO,
    SRC_ENTRY,
    SRC_NEWKEY
  } res_src_t;

  typedef struct packed {
    logic              req_load;
    logic              scan_init;
    logic              scan_step;
    logic              shift_init;
    logic              shift_step;
    logic              pos_tail;
    logic              pos_hit;
    logic              rd_head;
    logic              store;
    logic              pop;
    logic              res_load;
    logic [STAT_W-1:0] res_status;
    res_src_t          res_src;
    logic              out_load;
  } cmd_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              full;
    logic              empty;
    logic              hit;
    logic              scan_end;
    logic              shift_end;
    logic              out_free;
  } stat_t;

endpackage

// ===== hdl/prq_if.sv =====
// request and response channel interfaces
interface prq_req_if;
  import prq_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [MODE_W-1:0]        mode;
  logic [PID_W-1:0]         proc_id;
  logic [PRIO_W-1:0]        prio;
  logic signed [KEY_W-1:0]  search_key;

  modport source (output valid, mode, proc_id, prio, search_key, input ready);
  modport sink (input valid, mode, proc_id, prio, search_key, output ready);
endinterface

interface prq_rsp_if;
  import prq_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [STAT_W-1:0]        status;
  logic [PID_W-1:0]         out_pid;
  logic signed [KEY_W-1:0]  out_key;
  logic [PRIO_W-1:0]        out_prio;

  modport source (output valid, status, out_pid, out_key, out_prio, input ready);
  modport sink (input valid, status, out_pid, out_key, out_prio, output ready);
endinterface

// ===== hdl/prq_ctrl.sv =====
// sequencer of the ready queue: decodes a request and steps the datapath
module prq_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  output prq_pkg::cmd_t  cmd,
  input  prq_pkg::stat_t stat
);
  import prq_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_SCAN,
    S_SHIFT,
    S_STORE,
    S_POP,
    S_RESULT
  } state_t;

  state_t state, state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    cmd.res_src = SRC_ZERO;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.req_load = 1'b1;
          state_next   = S_DECIDE;
        end
      end
      S_DECIDE: begin
        unique case (stat.mode)
          MODE_ENQ: begin
            if (stat.full) begin
              cmd.res_load   = 1'b1;
              cmd.res_status = ST_FULL;
              state_next     = S_RESULT;
            end else begin
              cmd.pos_tail   = 1'b1;
              cmd.shift_init = 1'b1;
              state_next     = S_SHIFT;
            end
          end
          MODE_INS: begin
            if (stat.full) begin
              cmd.res_load   = 1'b1;
              cmd.res_status = ST_FULL;
              state_next     = S_RESULT;
            end else begin
              cmd.scan_init = 1'b1;
              state_next    = S_SCAN;
            end
          end
          MODE_DEQ: begin
            if (stat.empty) begin
              cmd.res_load   = 1'b1;
              cmd.res_status = ST_EMPTY;
              state_next     = S_RESULT;
            end else begin
              cmd.rd_head = 1'b1;
              state_next  = S_POP;
            end
          end
          MODE_FIND_PID, MODE_FIND_KEY: begin
            if (stat.empty) begin
              cmd.res_load   = 1'b1;
              cmd.res_status = ST_EMPTY;
              state_next     = S_RESULT;
            end else begin
              cmd.scan_init = 1'b1;
              state_next    = S_SCAN;
            end
          end
          default: begin
            cmd.res_load   = 1'b1;
            cmd.res_status = ST_OK;
            state_next     = S_RESULT;
          end
        endcase
      end
      S_SCAN: begin
        priority if (stat.hit) begin
          if (stat.mode == MODE_INS) begin
            cmd.pos_hit    = 1'b1;
            cmd.shift_init = 1'b1;
            state_next     = S_SHIFT;
          end else begin
            cmd.res_load   = 1'b1;
            cmd.res_status = ST_OK;
            cmd.res_src    = SRC_ENTRY;
            state_next     = S_RESULT;
          end
        end else if (stat.scan_end) begin
          if (stat.mode == MODE_INS) begin
            cmd.pos_tail   = 1'b1;
            cmd.shift_init = 1'b1;
            state_next     = S_SHIFT;
          end else begin
            cmd.res_load   = 1'b1;
            cmd.res_status = ST_MISS;
            state_next     = S_RESULT;
          end
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      S_SHIFT: begin
        if (stat.shift_end) begin
          state_next = S_STORE;
        end else begin
          cmd.shift_step = 1'b1;
        end
      end
      S_STORE: begin
        cmd.store      = 1'b1;
        cmd.res_load   = 1'b1;
        cmd.res_status = ST_OK;
        cmd.res_src    = SRC_NEWKEY;
        state_next     = S_RESULT;
      end
      S_POP: begin
        cmd.pop        = 1'b1;
        cmd.res_load   = 1'b1;
        cmd.res_status = ST_OK;
        cmd.res_src    = SRC_ENTRY;
        state_next     = S_RESULT;
      end
      S_RESULT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== hdl/prq_dp.sv =====
// datapath of the ready queue: circular entry memory, pointers, scan and result registers
`include "priority_ready_queue_top_assert.svh"

module prq_dp #(
  parameter int DEPTH
) (
  input  logic                              clk,
  input  logic                              rst,
  input  prq_pkg::cmd_t                     cmd,
  output prq_pkg::stat_t                    stat,
  input  logic [prq_pkg::MODE_W-1:0]        mode,
  input  logic [prq_pkg::PID_W-1:0]         proc_id,
  input  logic [prq_pkg::PRIO_W-1:0]        prio,
  input  logic signed [prq_pkg::KEY_W-1:0]  search_key,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [prq_pkg::STAT_W-1:0]        status,
  output logic [prq_pkg::PID_W-1:0]         out_pid,
  output logic signed [prq_pkg::KEY_W-1:0]  out_key,
  output logic [prq_pkg::PRIO_W-1:0]        out_prio
);
  import prq_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW:0]   DEPTH_W = (CW + 1)'(DEPTH);
  localparam logic [CW-1:0] FULL_C  = CW'(DEPTH);

  // latched request
  logic [MODE_W-1:0]       req_mode;
  logic [PID_W-1:0]        req_pid;
  logic [PRIO_W-1:0]       req_prio;
  logic signed [KEY_W-1:0] req_skey;

  // queue state
  logic [AW-1:0]    head;
  logic [CW-1:0]    occ;
  logic [KEY_W-1:0] next_key;

  // walk state: idx is the logical index being issued, dly_* the word in flight
  logic [CW-1:0] idx;
  logic [CW-1:0] dly_idx;
  logic          dly_valid;
  logic [CW-1:0] pos;

  // memory
  entry_t        mem [DEPTH];
  entry_t        rd_data;
  entry_t        wr_data;
  logic          rd_en, wr_en;
  logic [AW-1:0] rd_addr, wr_addr;

  // result staging
  logic [STAT_W-1:0]       res_status;
  logic [PID_W-1:0]        res_pid;
  logic signed [KEY_W-1:0] res_key;
  logic [PRIO_W-1:0]       res_prio;

  logic match;

  // logical index to memory address, wrapping around the ring
  function automatic logic [AW-1:0] phys(input logic [AW-1:0] base, input logic [CW-1:0] i);
    logic [CW:0] s;
    s = {{(CW + 1 - AW){1'b0}}, base} + {1'b0, i};
    if (s >= DEPTH_W) begin
      s = s - DEPTH_W;
    end
    return s[AW-1:0];
  endfunction

  always_comb begin
    unique case (req_mode)
      MODE_INS:      match = (rd_data.prio <= req_prio);
      MODE_FIND_PID: match = (rd_data.pid == req_pid);
      MODE_FIND_KEY: match = (rd_data.key == req_skey);
      default:       match = 1'b0;
    endcase
  end

  always_comb begin
    stat.mode      = req_mode;
    stat.full      = (occ == FULL_C);
    stat.empty     = (occ == '0);
    stat.hit       = dly_valid && match;
    stat.scan_end  = !dly_valid && (idx == occ);
    stat.shift_end = !dly_valid && (idx == pos);
    stat.out_free  = !out_valid || out_ready;
  end

  // memory port steering
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = head;
    wr_en   = 1'b0;
    wr_addr = phys(head, dly_idx);
    wr_data = rd_data;
    if (cmd.scan_step && (idx != occ)) begin
      rd_en   = 1'b1;
      rd_addr = phys(head, idx);
    end
    if (cmd.shift_step && (idx != pos)) begin
      rd_en   = 1'b1;
      rd_addr = phys(head, idx - 1'b1);
    end
    if (cmd.rd_head) begin
      rd_en   = 1'b1;
      rd_addr = head;
    end
    if (cmd.shift_step && dly_valid) begin
      wr_en = 1'b1;
    end
    if (cmd.store) begin
      wr_en        = 1'b1;
      wr_addr      = phys(head, pos);
      wr_data.pid  = req_pid;
      wr_data.key  = $signed(next_key);
      wr_data.prio = req_prio;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // request, walk and result registers
  always_ff @(posedge clk) begin
    if (cmd.req_load) begin
      req_mode <= mode;
      req_pid  <= proc_id;
      req_prio <= prio;
      req_skey <= search_key;
    end
    if (cmd.pos_tail) begin
      pos <= occ;
    end else if (cmd.pos_hit) begin
      pos <= dly_idx;
    end
    if (cmd.scan_step && (idx != occ)) begin
      dly_idx <= idx;
      idx     <= idx + 1'b1;
    end else if (cmd.shift_step && (idx != pos)) begin
      dly_idx <= idx;
      idx     <= idx - 1'b1;
    end else if (cmd.scan_init) begin
      idx <= '0;
    end else if (cmd.shift_init) begin
      idx <= occ;
    end
    if (cmd.res_load) begin
      res_status <= cmd.res_status;
      unique case (cmd.res_src)
        SRC_ENTRY: begin
          res_pid  <= rd_data.pid;
          res_key  <= rd_data.key;
          res_prio <= rd_data.prio;
        end
        SRC_NEWKEY: begin
          res_pid  <= '0;
          res_key  <= $signed(next_key);
          res_prio <= '0;
        end
        default: begin
          res_pid  <= '0;
          res_key  <= '0;
          res_prio <= '0;
        end
      endcase
    end
    if (cmd.out_load) begin
      status   <= res_status;
      out_pid  <= res_pid;
      out_key  <= res_key;
      out_prio <= res_prio;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      head      <= '0;
      occ       <= '0;
      next_key  <= FIRST_KEY;
      dly_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.scan_init || cmd.shift_init) begin
        dly_valid <= 1'b0;
      end else if (cmd.scan_step) begin
        dly_valid <= (idx != occ);
      end else if (cmd.shift_step) begin
        dly_valid <= (idx != pos);
      end
      if (cmd.store) begin
        occ      <= occ + 1'b1;
        next_key <= next_key - 1'b1;
      end else if (cmd.pop) begin
        occ  <= occ - 1'b1;
        head <= phys(head, CW'(1));
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  `PRQ_ASSERT_ALWAYS(a_occ_bound, occ <= FULL_C, "occupancy above depth")
  `PRQ_ASSERT_SAME(a_store_room, cmd.store, occ != FULL_C, "store into a full queue")
  `PRQ_ASSERT_NEXT(a_store_count, cmd.store, occ == $past(occ) + 1'b1, "store did not grow queue")
  `PRQ_ASSERT_SAME(a_shift_span, cmd.shift_step && dly_valid, (dly_idx > pos) && (dly_idx <= occ),
    "shift write outside the open gap")
  `PRQ_ASSERT_SAME(a_out_free, cmd.out_load, !out_valid || out_ready, "result overwrote a held word")

endmodule

// ===== hdl/priority_ready_queue_top.sv =====
// Priority ready queue: ordered queue of process entries with tail enqueue,
// priority insert, head dequeue and find by pid or by key.
// Channels: req carries one command word (mode, proc_id, prio, search_key);
// rsp returns exactly one word per command (status, out_pid, out_key, out_prio).
// One command is in work at a time; req.ready is high only while the sequencer
// is idle, and a finished word waits in the rsp register so the next command
// can be taken while the receiver has not yet taken it.
// Work per command from acceptance to rsp.valid, with n entries in the queue:
//   enqueue and dequeue move no other entries, status-only results skip the memory,
//   find is set by the entry scan reading one memory word a cycle,
//   priority insert makes a scan up to insert position p, then a
//   one-word-a-cycle move of the n - p entries behind p through the memory ports.
// Reset empties the queue and sets the key counter to 99; the entry memory
// is not cleared since no entry is read before it is written.
// A stalled receiver holds the rsp word; the block then finishes at most one
// more command and waits with it staged until the rsp register frees up.
module priority_ready_queue_top #(
  parameter int DEPTH = 128
) (
  input logic      clk,
  input logic      rst,
  prq_req_if.sink  req,
  prq_rsp_if.source rsp
);
  import prq_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  prq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .cmd      (cmd),
    .stat     (stat)
  );

  prq_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .mode       (req.mode),
    .proc_id    (req.proc_id),
    .prio       (req.prio),
    .search_key (req.search_key),
    .out_valid  (rsp.valid),
    .out_ready  (rsp.ready),
    .status     (rsp.status),
    .out_pid    (rsp.out_pid),
    .out_key    (rsp.out_key),
    .out_prio   (rsp.out_prio)
  );

endmodule

// ===== sim/tb_priority_ready_queue_top.sv =====
// self-checking testbench of the priority ready queue with random stimulus and idling
module tb_priority_ready_queue_top;
  timeunit 1ns;
  timeprecision 1ps;

  import prq_pkg::*;

  localparam int DUT_DEPTH    = 128;
  localparam int RAND_TARGET  = 550;
  localparam int HOLD_AT_WORD = 150;
  localparam int HOLD_CYCLES  = 1200;
  localparam int DRAIN_CYCLES = 2 * DUT_DEPTH + 40;
  localparam int IDLE_LIMIT   = 6000;

  // modes the block leaves undefined
  localparam logic [MODE_W-1:0] MODE_RSVD5 = 3'd5;
  localparam logic [MODE_W-1:0] MODE_RSVD6 = 3'd6;
  localparam logic [MODE_W-1:0] MODE_RSVD7 = 3'd7;

  localparam int SIDE_REQ = 0;
  localparam int SIDE_RSP = 1;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [PID_W-1:0]  pid;
    logic [PRIO_W-1:0] prio;
    logic [KEY_W-1:0]  skey;
  } req_word_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [PID_W-1:0]  pid;
    logic [KEY_W-1:0]  key;
    logic [PRIO_W-1:0] prio;
  } rsp_word_t;

  logic clk = 1'b0;
  logic rst;

  prq_req_if req_ch();
  prq_rsp_if rsp_ch();

  priority_ready_queue_top #(.DEPTH(DUT_DEPTH)) dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow of the queue contents, head at index 0
  entry_t           ready_list[$];
  logic [KEY_W-1:0] key_ctr = FIRST_KEY;

  req_word_t pending_cmds[$];
  rsp_word_t expected_rsp[$];

  // occupancy and key counter as the stimulus generator sees them
  int               gen_occ = 0;
  logic [KEY_W-1:0] gen_key = FIRST_KEY;

  int words_planned = 0;
  int words_sent    = 0;
  int rsp_seen      = 0;
  int fail_cnt      = 0;
  int idle_cycles   = 0;
  int req_gap       = 0;
  int rsp_stall     = 0;
  int hold_left     = 0;
  int calm_left[2];

  function automatic rsp_word_t apply_command(input req_word_t c);
    rsp_word_t r;
    entry_t    e;
    int        pos;
    int        i;
    r = '0;
    case (c.mode)
      MODE_ENQ, MODE_INS: begin
        if (ready_list.size() >= DUT_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          pos = ready_list.size();
          // backward scan leaves the first entry with prio not above the new one
          if (c.mode == MODE_INS) begin
            for (i = ready_list.size() - 1; i >= 0; i--) begin
              if (ready_list[i].prio <= c.prio) pos = i;
            end
          end
          e.pid  = c.pid;
          e.key  = key_ctr;
          e.prio = c.prio;
          ready_list.insert(pos, e);
          r.status = ST_OK;
          r.key    = key_ctr;
          key_ctr  = key_ctr - 1'b1;
        end
      end
      MODE_DEQ: begin
        if (ready_list.size() == 0) begin
          r.status = ST_EMPTY;
        end else begin
          e = ready_list.pop_front();
          r.status = ST_OK;
          r.pid    = e.pid;
          r.key    = e.key;
          r.prio   = e.prio;
        end
      end
      MODE_FIND_PID, MODE_FIND_KEY: begin
        if (ready_list.size() == 0) begin
          r.status = ST_EMPTY;
        end else begin
          pos = -1;
          for (i = ready_list.size() - 1; i >= 0; i--) begin
            if (c.mode == MODE_FIND_PID ? ready_list[i].pid == c.pid
                                        : ready_list[i].key == c.skey) pos = i;
          end
          if (pos < 0) begin
            r.status = ST_MISS;
          end else begin
            r.status = ST_OK;
            r.pid    = ready_list[pos].pid;
            r.key    = ready_list[pos].key;
            r.prio   = ready_list[pos].prio;
          end
        end
      end
      default: r.status = ST_OK;
    endcase
    return r;
  endfunction

  // mostly short gaps, a few long ones, and calm stretches with none
  function automatic int pick_gap(input int side);
    int r;
    if (calm_left[side] > 0) begin
      calm_left[side]--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) calm_left[side] = $urandom_range(20, 80);
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 20);
    return $urandom_range(40, 200);
  endfunction

  task automatic add_item(input logic [MODE_W-1:0] mode, input logic [PID_W-1:0] pid,
                          input logic [PRIO_W-1:0] prio, input logic [KEY_W-1:0] skey);
    req_word_t w;
    w.mode = mode;
    w.pid  = pid;
    w.prio = prio;
    w.skey = skey;
    pending_cmds.push_back(w);
    case (mode)
      MODE_ENQ, MODE_INS: begin
        if (gen_occ < DUT_DEPTH) begin
          gen_occ++;
          gen_key = gen_key - 1'b1;
        end
      end
      MODE_DEQ: if (gen_occ > 0) gen_occ--;
      default: ;
    endcase
  endtask

  task automatic rand_item(input int w_store, input int w_deq);
    int                r;
    logic [MODE_W-1:0] mode;
    logic [PID_W-1:0]  pid;
    logic [PRIO_W-1:0] prio;
    logic [KEY_W-1:0]  skey;
    r = $urandom_range(0, 99);
    if (r < 3) begin
      mode = MODE_W'($urandom_range(MODE_RSVD5, MODE_RSVD7));
    end else if (r < 3 + w_store) begin
      mode = $urandom_range(0, 1) ? MODE_INS : MODE_ENQ;
    end else if (r < 3 + w_store + w_deq) begin
      mode = MODE_DEQ;
    end else begin
      mode = $urandom_range(0, 1) ? MODE_FIND_KEY : MODE_FIND_PID;
    end
    // small pid pool so that pid searches hit
    pid = ($urandom_range(0, 9) < 7) ? PID_W'($urandom_range(0, 15)) : PID_W'($urandom);
    case ($urandom_range(0, 3))
      0: prio = PRIO_W'($urandom_range(0, 7) * 32);
      1: prio = $urandom_range(0, 1) ? 8'hff : 8'h00;
      default: prio = PRIO_W'($urandom);
    endcase
    // live keys lie just above the generator's key counter
    if ($urandom_range(0, 9) < 7) skey = gen_key + KEY_W'($urandom_range(1, gen_occ + 2));
    else skey = KEY_W'($urandom);
    add_item(mode, pid, prio, skey);
  endtask

  initial begin
    req_ch.valid      = 1'b0;
    req_ch.mode       = MODE_ENQ;
    req_ch.proc_id    = '0;
    req_ch.prio       = '0;
    req_ch.search_key = '0;
    rsp_ch.ready      = 1'b0;
    calm_left[SIDE_REQ] = 0;
    calm_left[SIDE_RSP] = 0;
    rst = 1'b1;

    // operations on an empty queue and undefined modes
    add_item(MODE_DEQ,      16'($urandom), 8'($urandom), 16'($urandom));
    add_item(MODE_FIND_PID, 16'h0000,      8'($urandom), 16'($urandom));
    add_item(MODE_FIND_KEY, 16'($urandom), 8'($urandom), FIRST_KEY);
    add_item(MODE_RSVD5,    16'hffff,      8'hff,        16'hffff);
    add_item(MODE_RSVD6,    16'($urandom), 8'($urandom), 16'($urandom));
    add_item(MODE_RSVD7,    16'h0000,      8'h00,        16'h0000);
    // field extremes and insert placement around equal priorities
    add_item(MODE_ENQ,      16'h0000,      8'h00,        16'($urandom));
    add_item(MODE_ENQ,      16'hffff,      8'hff,        16'($urandom));
    add_item(MODE_INS,      16'h1234,      8'h80,        16'($urandom));
    add_item(MODE_INS,      16'h4321,      8'hff,        16'($urandom));
    add_item(MODE_INS,      16'h0001,      8'h00,        16'($urandom));
    add_item(MODE_ENQ,      16'h8000,      8'h7f,        16'($urandom));
    add_item(MODE_INS,      16'h7fff,      8'h80,        16'($urandom));
    // finds that hit and miss
    add_item(MODE_FIND_PID, 16'hffff,      8'($urandom), 16'($urandom));
    add_item(MODE_FIND_PID, 16'habcd,      8'($urandom), 16'($urandom));
    add_item(MODE_FIND_KEY, 16'($urandom), 8'($urandom), FIRST_KEY);
    add_item(MODE_FIND_KEY, 16'($urandom), 8'($urandom), 16'h8000);
    add_item(MODE_FIND_KEY, 16'($urandom), 8'($urandom), 16'h7fff);
    add_item(MODE_RSVD5,    16'($urandom), 8'($urandom), 16'($urandom));
    add_item(MODE_DEQ,      16'($urandom), 8'($urandom), 16'($urandom));
    add_item(MODE_DEQ,      16'($urandom), 8'($urandom), 16'($urandom));
    add_item(MODE_FIND_PID, 16'h0000,      8'($urandom), 16'($urandom));

    repeat (100) rand_item(40, 25);
    // fill to the top, push against a full queue, then drain it
    while (gen_occ < DUT_DEPTH) rand_item(80, 8);
    add_item(MODE_ENQ, 16'($urandom), 8'($urandom), 16'($urandom));
    add_item(MODE_INS, 16'($urandom), 8'hff, 16'($urandom));
    add_item(MODE_INS, 16'($urandom), 8'h00, 16'($urandom));
    repeat (4) rand_item(0, 0);
    while (gen_occ > 0) rand_item(5, 70);
    while (pending_cmds.size() < RAND_TARGET) rand_item(40, 25);
    words_planned = pending_cmds.size();

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    while (words_sent < words_planned) @(posedge clk);
    while (expected_rsp.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  always @(posedge clk) begin : req_driver
    req_word_t w;
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        w.mode = req_ch.mode;
        w.pid  = req_ch.proc_id;
        w.prio = req_ch.prio;
        w.skey = req_ch.search_key;
        expected_rsp.push_back(apply_command(w));
        words_sent++;
        req_gap = pick_gap(SIDE_REQ);
      end
      if (req_ch.valid && !req_ch.ready) begin
        // word still on offer, hold it
      end else if (req_gap > 0) begin
        req_gap--;
        req_ch.valid <= 1'b0;
      end else if (pending_cmds.size() != 0) begin
        w = pending_cmds.pop_front();
        req_ch.mode       <= w.mode;
        req_ch.proc_id    <= w.pid;
        req_ch.prio       <= w.prio;
        req_ch.search_key <= w.skey;
        req_ch.valid      <= 1'b1;
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
      fail_cnt++;
    end
  endtask

  always @(posedge clk) begin : rsp_monitor
    rsp_word_t exp_w;
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        rsp_seen++;
        if (expected_rsp.size() == 0) begin
          $error("response word with nothing expected");
          fail_cnt++;
        end else begin
          exp_w = expected_rsp.pop_front();
          check_field("status",   exp_w.status, rsp_ch.status);
          check_field("out_pid",  exp_w.pid,    rsp_ch.out_pid);
          check_field("out_key",  exp_w.key,    $unsigned(rsp_ch.out_key));
          check_field("out_prio", exp_w.prio,   rsp_ch.out_prio);
        end
        // one long hold-off so the block backs up into the request side
        if (rsp_seen == HOLD_AT_WORD) hold_left = HOLD_CYCLES;
        else rsp_stall = pick_gap(SIDE_RSP);
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else if (rsp_stall > 0) begin
        rsp_stall--;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= 1'b1;
        if ($urandom_range(0, 9) == 0) rsp_stall = pick_gap(SIDE_RSP);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

endmodule
